// ----- rtl/core/htq_pkg.sv -----
// Shared types and constants for the heap timer queue.
// Holds the request/response words, heap entry, operation codes and FSM states.
// Depends on nothing.
package htq_pkg;

    localparam int HEAP_CAPACITY_DEF = 64;
    localparam int ID_SPACE_DEF      = 1024;
    localparam int ID_W              = 10;
    localparam int TIME_W            = 48;
    localparam int WAIT_W            = 31;

    // Operation codes
    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_ADJUST = 3'd1;
    localparam logic [2:0] ACT_FIRE   = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_POP    = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [2:0]        action;
        logic [ID_W-1:0]   timer_id;
        logic [WAIT_W-1:0] timeout_ms;
        logic [15:0]       elapsed_ms;
    } htq_in_t;

    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic [1:0]        status;
        logic              none_pending;
        logic [WAIT_W-1:0] next_wait_ms;
        logic              last;
    } htq_out_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] exp;
    } htq_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_CHK,
        S_RM,
        S_LAST,
        S_DN,
        S_DN_A,
        S_DN_B,
        S_DN_CMP,
        S_UP,
        S_UP_A,
        S_PUT,
        S_TICK,
        S_EMIT,
        S_INIT
    } htq_state_t;

endpackage

// ----- rtl/core/htq_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered; old data on a same-address write.
// Depends on nothing.
module htq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/heap_timer_queue.sv -----
// Heap timer queue top level: FSM, time counter, heap and id map memories.
// Depends on htq_pkg and htq_ram.
//
// Timer queue kept as a binary min-heap in one synchronous RAM, with a second
// RAM mapping each timer id to its heap position. One request word is taken
// at a time; each produces one response word, or for a tick one word per
// expired timer (earliest first, or a single word if none has expired) with
// last set on the final one. Every heap read goes through the single read
// port of the heap RAM, one read a cycle, so cost follows the sift length:
// an insert climbs, a removal or re-arm descends and then may climb, and a
// tick pays a removal once per expired timer. An id map entry counts only if
// it points below the heap count at a heap slot holding the same id, so clear
// is immediate; after reset the map is zeroed by a pass over all ID_SPACE
// entries, during which req_stall stays high. The response sits in an output
// register, so a new request is taken while a response waits to be taken.
module heap_timer_queue #(
    parameter int HEAP_CAPACITY = htq_pkg::HEAP_CAPACITY_DEF,
    parameter int ID_SPACE      = htq_pkg::ID_SPACE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  htq_pkg::htq_in_t req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output htq_pkg::htq_out_t rsp
);

    import htq_pkg::*;

    localparam int PW  = $clog2(HEAP_CAPACITY);
    localparam int CW  = $clog2(HEAP_CAPACITY + 1);
    localparam int KW  = PW + 2;
    localparam int MAW = $clog2(ID_SPACE);
    localparam int XW  = (MAW > ID_W) ? MAW : ID_W;

    htq_state_t state_reg, state_next;

    logic [2:0]        act_reg, act_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] exp_reg, exp_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MAW-1:0]    init_reg, init_next;
    htq_entry_t        top_reg, top_next;
    htq_entry_t        cur_reg, cur_next;
    htq_entry_t        ch_reg, ch_next;
    logic [PW-1:0]     cidx_reg, cidx_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              moved_reg, moved_next;
    logic              fired_reg, fired_next;
    logic [ID_W-1:0]   fid_reg, fid_next;
    logic [1:0]        status_reg, status_next;
    logic              tick_reg, tick_next;
    logic              out_valid_reg, out_valid_next;
    htq_out_t          out_reg, out_next;

    // Memory ports
    logic          hwe;
    logic [PW-1:0] hwa, hra;
    htq_entry_t    hwd, hrd;
    logic          mwe;
    logic [MAW-1:0] mwa, mra;
    logic [PW-1:0] mwd, mrd;
    logic [XW-1:0] req_id_wide, wr_id_wide;

    // Conditions
    logic              known;
    logic [CW-1:0]     n_cnt;
    logic [KW-1:0]     cc, cc1;
    logic [PW-1:0]     parent;
    logic              map_hit, id_match, full, empty, rm_more;
    logic              dn_has, dn_has2, take_right, dn_stop, up_stop, at_root;
    logic              expired, out_load, emit_last, absent;
    logic              init_busy, init_done;
    logic [TIME_W-1:0] diff;
    logic [WAIT_W-1:0] wait_ms;

    htq_ram #(.DEPTH(HEAP_CAPACITY), .WIDTH($bits(htq_entry_t))) u_heap (
        .clk   (clk),
        .we    (hwe),
        .waddr (hwa),
        .wdata (hwd),
        .raddr (hra),
        .rdata (hrd)
    );

    htq_ram #(.DEPTH(ID_SPACE), .WIDTH(PW)) u_map (
        .clk   (clk),
        .we    (mwe),
        .waddr (mwa),
        .wdata (mwd),
        .raddr (mra),
        .rdata (mrd)
    );

    // Map ids to map addresses; zero the map while the reset pass runs
    assign init_busy   = state_reg == S_INIT;
    assign init_done   = init_reg == MAW'(ID_SPACE - 1);
    assign req_id_wide = XW'(req.timer_id);
    assign mra         = req_id_wide[MAW-1:0];
    assign wr_id_wide  = XW'(hwd.id);
    assign mwa         = init_busy ? init_reg : wr_id_wide[MAW-1:0];
    assign mwe         = hwe || init_busy;
    assign mwd         = init_busy ? '0 : hwa;

    // Decode conditions
    assign known      = 32'(req.timer_id) < 32'(ID_SPACE);
    assign n_cnt      = count_reg - CW'(1);
    assign cc         = KW'({pos_reg, 1'b1});
    assign cc1        = cc + KW'(1);
    assign parent     = (pos_reg - PW'(1)) >> 1;
    assign map_hit    = CW'(mrd) < count_reg;
    assign id_match   = hrd.id == id_reg;
    assign full       = count_reg == CW'(HEAP_CAPACITY);
    assign empty      = count_reg == '0;
    assign rm_more    = CW'(pos_reg) < n_cnt;
    assign dn_has     = cc < KW'(count_reg);
    assign dn_has2    = cc1 < KW'(count_reg);
    assign take_right = hrd.exp < ch_reg.exp;
    assign dn_stop    = cur_reg.exp < ch_reg.exp;
    assign up_stop    = hrd.exp < cur_reg.exp;
    assign at_root    = pos_reg == '0;
    assign expired    = !empty && !(time_reg < top_reg.exp);
    assign out_load   = !out_valid_reg || !rsp_stall;
    assign emit_last  = !(tick_reg && fired_reg) || !expired;
    assign absent     = (state_reg == S_MAP && !map_hit) ||
                        (state_reg == S_CHK && !id_match);

    // Wait until the earliest expiry, clamped
    assign diff = top_reg.exp - time_reg;
    always_comb
    begin
        wait_ms = '0;
        if (!empty && time_reg < top_reg.exp)
        begin
            wait_ms = (|diff[TIME_W-1:WAIT_W]) ? {WAIT_W{1'b1}} : diff[WAIT_W-1:0];
        end
    end

    // Heap read address per state
    always_comb
    begin
        case (state_reg)
            S_MAP:   hra = mrd;
            S_RM:    hra = n_cnt[PW-1:0];
            S_DN:    hra = cc[PW-1:0];
            S_DN_A:  hra = cc1[PW-1:0];
            S_UP:    hra = parent;
            default: hra = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (init_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.action)
                        ACT_ADD, ACT_ADJUST, ACT_FIRE:
                            state_next = known ? S_MAP : S_EMIT;
                        ACT_TICK: state_next = S_TICK;
                        ACT_POP:  state_next = empty ? S_EMIT : S_RM;
                        default:  state_next = S_EMIT;
                    endcase
                end
            end
            S_MAP, S_CHK:
            begin
                if (absent)
                begin
                    state_next = (act_reg == ACT_ADD && !full) ? S_UP : S_EMIT;
                end
                else if (state_reg == S_MAP)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = (act_reg == ACT_FIRE) ? S_RM : S_DN;
                end
            end
            S_RM:     state_next = rm_more ? S_LAST : S_EMIT;
            S_LAST:   state_next = S_DN;
            S_DN:     state_next = dn_has ? S_DN_A : (moved_reg ? S_PUT : S_UP);
            S_DN_A:   state_next = dn_has2 ? S_DN_B : S_DN_CMP;
            S_DN_B:   state_next = S_DN_CMP;
            S_DN_CMP: state_next = dn_stop ? (moved_reg ? S_PUT : S_UP) : S_DN;
            S_UP:     state_next = at_root ? S_PUT : S_UP_A;
            S_UP_A:   state_next = up_stop ? S_PUT : S_UP;
            S_PUT:    state_next = S_EMIT;
            S_TICK:   state_next = expired ? S_RM : S_EMIT;
            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = emit_last ? S_IDLE : S_TICK;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath, memory writes and response
    always_comb
    begin
        act_next       = act_reg;
        id_next        = id_reg;
        exp_next       = exp_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        init_next      = init_reg;
        cur_next       = cur_reg;
        ch_next        = ch_reg;
        cidx_next      = cidx_reg;
        pos_next       = pos_reg;
        moved_next     = moved_reg;
        fired_next     = fired_reg;
        fid_next       = fid_reg;
        status_next    = status_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        hwe            = 1'b0;
        hwa            = pos_reg;
        hwd            = cur_reg;
        case (state_reg)
            S_INIT:   init_next = init_reg + MAW'(1);
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req.action;
                    id_next     = req.timer_id;
                    exp_next    = time_reg + TIME_W'(req.timeout_ms);
                    fired_next  = 1'b0;
                    fid_next    = '0;
                    status_next = ST_OK;
                    tick_next   = 1'b0;
                    moved_next  = 1'b0;
                    pos_next    = '0;
                    case (req.action)
                        ACT_ADD, ACT_ADJUST, ACT_FIRE:
                            if (!known)
                            begin
                                status_next = ST_UNKNOWN;
                            end
                        ACT_TICK:
                        begin
                            time_next = time_reg + TIME_W'(req.elapsed_ms);
                            tick_next = 1'b1;
                        end
                        ACT_POP:
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                        ACT_CLEAR: count_next = '0;
                        default: ;
                    endcase
                end
            end
            S_MAP, S_CHK:
            begin
                if (absent)
                begin
                    // Insert a new id at the tail, or report why not
                    if (act_reg != ACT_ADD)
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cur_next   = '{id: id_reg, exp: exp_reg};
                        pos_next   = count_reg[PW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (state_reg == S_MAP)
                begin
                    pos_next = mrd;
                end
                else if (act_reg == ACT_FIRE)
                begin
                    fired_next = 1'b1;
                    fid_next   = id_reg;
                end
                else
                begin
                    cur_next = '{id: id_reg, exp: exp_reg};
                end
            end
            S_RM:     count_next = n_cnt;
            S_LAST:   cur_next = hrd;
            S_DN_A:
            begin
                ch_next   = hrd;
                cidx_next = cc[PW-1:0];
            end
            S_DN_B:
            begin
                if (take_right)
                begin
                    ch_next   = hrd;
                    cidx_next = cc1[PW-1:0];
                end
            end
            S_DN_CMP:
            begin
                // Move the smaller child up into the hole
                if (!dn_stop)
                begin
                    hwe        = 1'b1;
                    hwd        = ch_reg;
                    pos_next   = cidx_reg;
                    moved_next = 1'b1;
                end
            end
            S_UP_A:
            begin
                // Move the parent down into the hole
                if (!up_stop)
                begin
                    hwe      = 1'b1;
                    hwd      = hrd;
                    pos_next = parent;
                end
            end
            S_PUT:    hwe = 1'b1;
            S_TICK:
            begin
                if (expired)
                begin
                    fired_next = 1'b1;
                    fid_next   = top_reg.id;
                    pos_next   = '0;
                    moved_next = 1'b0;
                end
                else
                begin
                    fired_next = 1'b0;
                    fid_next   = '0;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.fired        = fired_reg;
                    out_next.fired_id     = fid_reg;
                    out_next.status       = status_reg;
                    out_next.none_pending = empty;
                    out_next.next_wait_ms = wait_ms;
                    out_next.last         = emit_last;
                end
            end
            default: ;
        endcase
    end

    // Mirror heap slot zero
    assign top_next = (hwe && hwa == '0) ? hwd : top_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= '0;
            time_reg      <= '0;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        exp_reg    <= exp_next;
        top_reg    <= top_next;
        cur_reg    <= cur_next;
        ch_reg     <= ch_next;
        cidx_reg   <= cidx_next;
        pos_reg    <= pos_next;
        moved_reg  <= moved_next;
        fired_reg  <= fired_next;
        fid_reg    <= fid_next;
        status_reg <= status_next;
        tick_reg   <= tick_next;
        out_reg    <= out_next;
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
